// File: design/ihe_pkg.sv
// Shared types and constants for the IPv4 header encapsulator.
package ihe_pkg;

    localparam logic       REQ_START   = 1'b0;
    localparam logic       REQ_BYTE    = 1'b1;
    localparam logic [15:0] MAX_PAYLOAD = 16'd65515;
    localparam logic [15:0] HDR_LEN     = 16'd20;
    localparam logic [4:0]  HDR_LAST    = 5'd19;
    localparam logic [7:0]  VER_IHL     = 8'h45;

    // Configuration register indexes (byte address bits [3:2]).
    localparam logic [1:0] REG_SRC   = 2'd0;
    localparam logic [1:0] REG_DST   = 2'd1;
    localparam logic [1:0] REG_TTL   = 2'd2;
    localparam logic [1:0] REG_PROTO = 2'd3;

    localparam int CMD_DEPTH = 4;
    localparam int CMD_AW    = $clog2(CMD_DEPTH);

    typedef struct packed {
        logic        req_type;
        logic [15:0] payload_length;
        logic [7:0]  payload_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       packet_end;
        logic       error_flag;
    } t_out_item;

    typedef enum logic [1:0] {
        CMD_HDR = 2'd0,
        CMD_PAY = 2'd1,
        CMD_ERR = 2'd2
    } t_cmd_kind;

    // Classified request handed from the front end to the back end.
    typedef struct packed {
        t_cmd_kind   kind;
        logic [15:0] data;
        logic        last;
    } t_cmd;

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [7:0]  ttl;
        logic [7:0]  proto;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

endpackage

// File: design/ihe_front.sv
// Front end: accepts requests, tracks the open packet and classifies each request.
module ihe_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  ihe_pkg::t_in_item i_item,
    input  ihe_pkg::t_fifo_status i_status,
    output logic              o_ready,
    output logic              o_push,
    output ihe_pkg::t_cmd     o_cmd
);

    logic        r_open;
    logic [15:0] r_rem;
    logic        n_open;
    logic [15:0] n_rem;
    logic [15:0] w_rem_dec;

    assign o_ready   = !i_status.full;
    assign o_push    = i_valid && !i_status.full;
    assign w_rem_dec = r_rem - 16'd1;

    always_comb begin
        n_open     = r_open;
        n_rem      = r_rem;
        o_cmd.kind = ihe_pkg::CMD_ERR;
        o_cmd.data = '0;
        o_cmd.last = 1'b1;
        if (i_item.req_type == ihe_pkg::REQ_BYTE) begin
            if (r_open) begin
                o_cmd.kind = ihe_pkg::CMD_PAY;
                o_cmd.data = {8'd0, i_item.payload_byte};
                o_cmd.last = (w_rem_dec == 16'd0);
                n_rem      = w_rem_dec;
                n_open     = (w_rem_dec != 16'd0);
            end
        end else if (i_item.payload_length > ihe_pkg::MAX_PAYLOAD) begin
            // An oversize start drops whatever packet was open.
            n_open = 1'b0;
            n_rem  = '0;
        end else begin
            o_cmd.kind = ihe_pkg::CMD_HDR;
            o_cmd.data = i_item.payload_length;
            o_cmd.last = (i_item.payload_length == 16'd0);
            n_rem      = i_item.payload_length;
            n_open     = (i_item.payload_length != 16'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_rem  <= '0;
        end else if (o_push) begin
            r_open <= n_open;
            r_rem  <= n_rem;
        end
    end

endmodule

// File: design/ihe_cmd_fifo.sv
// Short command queue between the front end and the back end.
module ihe_cmd_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  ihe_pkg::t_cmd         i_cmd,
    input  logic                  i_pop,
    output ihe_pkg::t_fifo_status o_status,
    output ihe_pkg::t_cmd         o_head
);

    ihe_pkg::t_cmd                 r_mem [ihe_pkg::CMD_DEPTH];
    logic [ihe_pkg::CMD_AW-1:0]    r_wptr;
    logic [ihe_pkg::CMD_AW-1:0]    r_rptr;
    logic [ihe_pkg::CMD_AW:0]      r_count;

    assign o_status.full  = (r_count == (ihe_pkg::CMD_AW+1)'(ihe_pkg::CMD_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: design/ihe_back.sv
// Back end: expands commands into header, payload and error bytes.
module ihe_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ihe_pkg::t_cmd         i_cmd,
    input  ihe_pkg::t_fifo_status i_status,
    input  ihe_pkg::t_cfg         i_cfg,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output ihe_pkg::t_out_item    o_rsp
);

    logic               r_busy;
    logic [4:0]         r_idx;
    logic [15:0]        r_total;
    logic               r_zero;
    logic               r_out_valid;
    ihe_pkg::t_out_item r_out;
    logic [17:0]        r_s1;
    logic [19:0]        r_s2;
    logic [16:0]        r_f1;
    logic [15:0]        r_ck;
    logic               w_load;
    logic [7:0]         w_hdr_byte;

    assign w_load  = !r_out_valid || i_ready;
    assign o_pop   = w_load && !r_busy && !i_status.empty;
    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

    // Checksum pipeline runs every cycle off the latched total length; the
    // result settles well before the checksum bytes go out.
    always_ff @(posedge i_clk) begin
        r_s1 <= 18'({ihe_pkg::VER_IHL, 8'd0}) + 18'(r_total)
              + 18'({i_cfg.ttl, i_cfg.proto}) + 18'(i_cfg.src[31:16]);
        r_s2 <= 20'(r_s1) + 20'(i_cfg.src[15:0]) + 20'(i_cfg.dst[31:16])
              + 20'(i_cfg.dst[15:0]);
        r_f1 <= 17'(r_s2[19:16]) + 17'(r_s2[15:0]);
        r_ck <= ~(r_f1[15:0] + 16'(r_f1[16]));
    end

    always_comb begin
        unique case (r_idx)
            5'd0:    w_hdr_byte = ihe_pkg::VER_IHL;
            5'd2:    w_hdr_byte = r_total[15:8];
            5'd3:    w_hdr_byte = r_total[7:0];
            5'd8:    w_hdr_byte = i_cfg.ttl;
            5'd9:    w_hdr_byte = i_cfg.proto;
            5'd10:   w_hdr_byte = r_ck[15:8];
            5'd11:   w_hdr_byte = r_ck[7:0];
            5'd12:   w_hdr_byte = i_cfg.src[31:24];
            5'd13:   w_hdr_byte = i_cfg.src[23:16];
            5'd14:   w_hdr_byte = i_cfg.src[15:8];
            5'd15:   w_hdr_byte = i_cfg.src[7:0];
            5'd16:   w_hdr_byte = i_cfg.dst[31:24];
            5'd17:   w_hdr_byte = i_cfg.dst[23:16];
            5'd18:   w_hdr_byte = i_cfg.dst[15:8];
            5'd19:   w_hdr_byte = i_cfg.dst[7:0];
            default: w_hdr_byte = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            if (r_busy) begin
                r_out.out_byte   <= w_hdr_byte;
                r_out.packet_end <= (r_idx == ihe_pkg::HDR_LAST) && r_zero;
                r_out.error_flag <= 1'b0;
                r_out_valid      <= 1'b1;
                r_idx            <= r_idx + 5'd1;
                if (r_idx == ihe_pkg::HDR_LAST) begin
                    r_busy <= 1'b0;
                end
            end else if (!i_status.empty) begin
                r_out_valid <= 1'b1;
                unique case (i_cmd.kind)
                    ihe_pkg::CMD_HDR: begin
                        // First header byte goes out with the pop itself.
                        r_out.out_byte   <= ihe_pkg::VER_IHL;
                        r_out.packet_end <= 1'b0;
                        r_out.error_flag <= 1'b0;
                        r_busy           <= 1'b1;
                        r_idx            <= 5'd1;
                        r_total          <= i_cmd.data + ihe_pkg::HDR_LEN;
                        r_zero           <= i_cmd.last;
                    end
                    ihe_pkg::CMD_PAY: begin
                        r_out.out_byte   <= i_cmd.data[7:0];
                        r_out.packet_end <= i_cmd.last;
                        r_out.error_flag <= 1'b0;
                    end
                    default: begin
                        r_out.out_byte   <= 8'd0;
                        r_out.packet_end <= 1'b1;
                        r_out.error_flag <= 1'b1;
                    end
                endcase
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// File: design/ipv4_header_encapsulator_core.sv
// Top level: configuration registers, front end, command queue and back end.
// An accepted request passes through the command queue and the output register before its first result shows.
// Throughput: one payload byte per cycle while the output is not stalled; a start request yields 20 header bytes.
// The header byte sequencer in the back end sets the rate; a four-entry queue absorbs stalls.
// Reset is synchronous and active low; it empties the queue and output register and
// returns the configuration registers to source 0, destination 0, TTL 255, protocol 1.
module ipv4_header_encapsulator_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  ihe_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output ihe_pkg::t_out_item o_rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    ihe_pkg::t_cfg         r_cfg;
    ihe_pkg::t_cmd         w_push_cmd;
    ihe_pkg::t_cmd         w_head;
    ihe_pkg::t_fifo_status w_status;
    logic                  w_push;
    logic                  w_pop;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src   <= '0;
            r_cfg.dst   <= '0;
            r_cfg.ttl   <= 8'd255;
            r_cfg.proto <= 8'd1;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                ihe_pkg::REG_SRC:   r_cfg.src   <= pwdata;
                ihe_pkg::REG_DST:   r_cfg.dst   <= pwdata;
                ihe_pkg::REG_TTL:   r_cfg.ttl   <= pwdata[7:0];
                ihe_pkg::REG_PROTO: r_cfg.proto <= pwdata[7:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            ihe_pkg::REG_SRC:   prdata = r_cfg.src;
            ihe_pkg::REG_DST:   prdata = r_cfg.dst;
            ihe_pkg::REG_TTL:   prdata = {24'd0, r_cfg.ttl};
            ihe_pkg::REG_PROTO: prdata = {24'd0, r_cfg.proto};
        endcase
    end

    ihe_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_item   (i_item),
        .i_status (w_status),
        .o_ready  (o_ready),
        .o_push   (w_push),
        .o_cmd    (w_push_cmd)
    );

    ihe_cmd_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_push_cmd),
        .i_pop    (w_pop),
        .o_status (w_status),
        .o_head   (w_head)
    );

    ihe_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_head),
        .i_status (w_status),
        .i_cfg    (r_cfg),
        .o_pop    (w_pop),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_rsp    (o_rsp)
    );

endmodule

// File: design/ihe_checker.sv
// Port-level checks for the encapsulator core, bound to the top level.
module ihe_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_ready,
    input ihe_pkg::t_out_item o_rsp
);

    // A stalled result must hold.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_rsp))
        else $error("stalled result changed");

    // Every rejected request closes its result.
    a_err_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.error_flag |-> o_rsp.packet_end)
        else $error("error result without packet end");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.error_flag |-> o_rsp.out_byte == 8'd0)
        else $error("error result with nonzero byte");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind ipv4_header_encapsulator_core ihe_checker u_ihe_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_rsp   (o_rsp)
);

// File: test/tb.sv
// Testbench for the IPv4 header encapsulator: directed and random traffic checked against a predictor.
module tb;

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    ihe_pkg::t_in_item    i_item  = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    ihe_pkg::t_out_item   o_rsp;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [3:0]           paddr   = '0;
    logic [31:0]          pwdata  = '0;
    logic [31:0]          prdata;
    logic                 pready;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned reqs_sent      = 0;
    int unsigned mismatch_cnt   = 0;

    // Predicted packet bytes in wire order, plus the predictor's own state.
    ihe_pkg::t_out_item wire_bytes_q[$];
    ihe_pkg::t_cfg      shadow_cfg;
    logic [15:0]        pay_left;
    logic               pkt_open;

    ipv4_header_encapsulator_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rsp   (o_rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("FAILED: results differ");
        $finish;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic void report_mismatch(input string what, input logic [31:0] want,
                                            input logic [31:0] got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("mismatch in %s: expected %h, got %h", what, want, got);
    endfunction

    function automatic void push_wire_byte(input logic [7:0] b, input logic last,
                                           input logic err);
        ihe_pkg::t_out_item r;
        r.out_byte   = b;
        r.packet_end = last;
        r.error_flag = err;
        wire_bytes_q.push_back(r);
    endfunction

    function automatic void predict_wire_bytes(input ihe_pkg::t_in_item it);
        logic [7:0]  hdr [20];
        logic [15:0] total;
        logic [31:0] sum;
        int          k;
        if (it.req_type == ihe_pkg::REQ_BYTE) begin
            if (!pkt_open) begin
                push_wire_byte(8'h00, 1'b1, 1'b1);
            end else begin
                pay_left = pay_left - 16'd1;
                pkt_open = (pay_left != 16'd0);
                push_wire_byte(it.payload_byte, !pkt_open, 1'b0);
            end
        end else if (it.payload_length > ihe_pkg::MAX_PAYLOAD) begin
            // An oversize start also drops whatever packet was still open.
            pkt_open = 1'b0;
            pay_left = '0;
            push_wire_byte(8'h00, 1'b1, 1'b1);
        end else begin
            total = it.payload_length + ihe_pkg::HDR_LEN;
            for (k = 0; k < 20; k++) hdr[k] = 8'h00;
            hdr[0] = ihe_pkg::VER_IHL;
            hdr[2] = total[15:8];
            hdr[3] = total[7:0];
            hdr[8] = shadow_cfg.ttl;
            hdr[9] = shadow_cfg.proto;
            for (k = 0; k < 4; k++) begin
                hdr[12 + k] = shadow_cfg.src[31 - 8 * k -: 8];
                hdr[16 + k] = shadow_cfg.dst[31 - 8 * k -: 8];
            end
            sum = '0;
            for (k = 0; k < 10; k++) sum = sum + {16'h0000, hdr[2 * k], hdr[2 * k + 1]};
            while (sum > 32'h0000_ffff) sum = (sum >> 16) + (sum & 32'h0000_ffff);
            sum = ~sum;
            hdr[10] = sum[15:8];
            hdr[11] = sum[7:0];
            for (k = 0; k < 20; k++)
                push_wire_byte(hdr[k], (it.payload_length == 16'd0) && (k == 19), 1'b0);
            pay_left = it.payload_length;
            pkt_open = (it.payload_length != 16'd0);
        end
    endfunction

    always @(posedge i_clk) begin : check_rsp
        ihe_pkg::t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            if (wire_bytes_q.size() == 0) begin
                report_mismatch("unexpected result", 32'h0, {22'h0, o_rsp});
            end else begin
                want = wire_bytes_q.pop_front();
                if (o_rsp.out_byte !== want.out_byte)
                    report_mismatch("out_byte", 32'(want.out_byte), 32'(o_rsp.out_byte));
                if (o_rsp.packet_end !== want.packet_end)
                    report_mismatch("packet_end", 32'(want.packet_end),
                                    32'(o_rsp.packet_end));
                if (o_rsp.error_flag !== want.error_flag)
                    report_mismatch("error_flag", 32'(want.error_flag),
                                    32'(o_rsp.error_flag));
            end
        end
    end

    // Valid is left high after acceptance; the next request either replaces the
    // payload or lowers valid for an idle gap.
    task automatic send_req(input ihe_pkg::t_in_item it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (!o_ready);
        predict_wire_bytes(it);
        reqs_sent++;
    endtask

    task automatic send_start(input logic [15:0] len);
        ihe_pkg::t_in_item it;
        it.req_type       = ihe_pkg::REQ_START;
        it.payload_length = len;
        it.payload_byte   = 8'($urandom_range(0, 255));
        send_req(it);
    endtask

    task automatic send_byte(input logic [7:0] b);
        ihe_pkg::t_in_item it;
        it.req_type       = ihe_pkg::REQ_BYTE;
        it.payload_length = 16'($urandom_range(0, 65535));
        it.payload_byte   = b;
        send_req(it);
    endtask

    task automatic send_packet(input logic [15:0] len);
        int unsigned n;
        send_start(len);
        for (n = 0; n < len; n++) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (wire_bytes_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // One APB transfer; a following transfer may start its setup phase at once.
    task automatic apb_transfer(input logic wr, input logic [1:0] idx, input logic [31:0] data,
                                output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
    endtask

    task automatic check_config();
        logic [31:0] rd;
        apb_transfer(1'b0, ihe_pkg::REG_SRC, '0, rd);
        if (rd !== shadow_cfg.src) report_mismatch("source register", shadow_cfg.src, rd);
        apb_transfer(1'b0, ihe_pkg::REG_DST, '0, rd);
        if (rd !== shadow_cfg.dst) report_mismatch("destination register", shadow_cfg.dst, rd);
        apb_transfer(1'b0, ihe_pkg::REG_TTL, '0, rd);
        if (rd !== {24'h0, shadow_cfg.ttl})
            report_mismatch("ttl register", {24'h0, shadow_cfg.ttl}, rd);
        apb_transfer(1'b0, ihe_pkg::REG_PROTO, '0, rd);
        if (rd !== {24'h0, shadow_cfg.proto})
            report_mismatch("protocol register", {24'h0, shadow_cfg.proto}, rd);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_config(input logic [31:0] src, input logic [31:0] dst,
                               input logic [7:0] ttl, input logic [7:0] proto);
        logic [31:0] rd;
        wait_idle();
        apb_transfer(1'b1, ihe_pkg::REG_SRC, src, rd);
        apb_transfer(1'b1, ihe_pkg::REG_DST, dst, rd);
        apb_transfer(1'b1, ihe_pkg::REG_TTL, {24'h0, ttl}, rd);
        apb_transfer(1'b1, ihe_pkg::REG_PROTO, {24'h0, proto}, rd);
        shadow_cfg.src   = src;
        shadow_cfg.dst   = dst;
        shadow_cfg.ttl   = ttl;
        shadow_cfg.proto = proto;
        check_config();
    endtask

    task automatic test_reset_values();
        check_config();
    endtask

    task automatic test_directed_cases();
        // A byte with nothing open is rejected.
        send_byte(8'h3c);
        // An empty payload marks the last header byte as the end of the packet.
        send_start(16'd0);
        send_start(16'd1);
        send_byte(8'hff);
        send_start(16'd3);
        send_byte(8'h00);
        send_byte(8'ha5);
        send_byte(8'h5a);
        // Largest legal length, abandoned by a new start after one byte.
        send_start(ihe_pkg::MAX_PAYLOAD);
        send_byte(8'h12);
        send_start(16'd2);
        send_byte(8'h80);
        send_byte(8'h7f);
        // Oversize lengths are rejected and leave no packet open.
        send_start(ihe_pkg::MAX_PAYLOAD + 16'd1);
        send_byte(8'h01);
        send_start(16'd5);
        send_byte(8'hc3);
        send_start(16'hffff);
        send_byte(8'h66);
    endtask

    task automatic test_register_extremes();
        load_config(32'h0000_0000, 32'h0000_0000, 8'h00, 8'h00);
        send_packet(16'd0);
        send_packet(16'd2);
        // All-ones fields make the checksum sum carry out of 16 bits, so it needs a fold.
        load_config(32'hffff_ffff, 32'hffff_ffff, 8'hff, 8'hff);
        send_packet(16'd0);
        send_packet(16'd2);
        load_config(32'hc0a8_0001, 32'h0a00_00fe, 8'h40, 8'h11);
        send_packet(16'd4);
    endtask

    task automatic send_random_packet();
        int unsigned pick;
        int unsigned len;
        int unsigned n;
        pick = $urandom_range(0, 99);
        if (pick < 72) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
            send_packet(16'(len));
        end else if (pick < 84) begin
            // Truncated packet, often with a large length; the next start abandons it.
            len = ($urandom_range(0, 1) == 0) ? $urandom_range(2, 12)
                                              : $urandom_range(13, ihe_pkg::MAX_PAYLOAD);
            send_start(16'(len));
            n = $urandom_range(0, (len - 1 < 5) ? len - 1 : 5);
            repeat (n) send_byte(8'($urandom_range(0, 255)));
        end else if (pick < 93) begin
            send_byte(8'($urandom_range(0, 255)));
        end else begin
            send_start(16'($urandom_range(ihe_pkg::MAX_PAYLOAD + 1, 65535)));
        end
    endtask

    task automatic test_random_traffic(input int unsigned n_reqs, input int unsigned idle_pct,
                                       input int unsigned stall_pct);
        int unsigned stop_at;
        load_config($urandom, $urandom, 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at        = reqs_sent + n_reqs;
        while (reqs_sent < stop_at) send_random_packet();
    endtask

    initial begin
        shadow_cfg.src   = 32'h0;
        shadow_cfg.dst   = 32'h0;
        shadow_cfg.ttl   = 8'hff;
        shadow_cfg.proto = 8'h01;
        pay_left         = '0;
        pkt_open         = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_directed_cases();
        test_register_extremes();
        test_random_traffic(60, 0, 0);
        test_random_traffic(60, 87, 0);
        test_random_traffic(60, 0, 87);
        test_random_traffic(60, 9, 9);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait_idle();
        if (mismatch_cnt == 0 && wire_bytes_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
